/* hw/rtl/decimal_text_to_scaled_integer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to scaled integer unit
// Shared concurrent-assertion wrappers with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_SCALED_INTEGER_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_SCALED_INTEGER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DTSI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DTSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dtsi_pkg.sv */
// ----------------------------------------------------------------------------
// dtsi_pkg
// Types, character codes, status codes and power-of-ten table for the
// decimal text to scaled integer unit.
// ----------------------------------------------------------------------------
package dtsi_pkg;

    localparam int unsigned C_MAX_DIGITS = 18;

    localparam int unsigned C_CHAR_W     = 8;
    localparam int unsigned C_VALUE_W    = 61;
    localparam int unsigned C_STATUS_W   = 2;
    localparam int unsigned C_CFG_IDX_W  = 4;
    localparam int unsigned C_CFG_DATA_W = 5;
    localparam int unsigned C_EXP_W      = 5;
    localparam int unsigned C_FCNT_W     = 6;
    localparam int unsigned C_MAG_W      = 60;
    localparam int unsigned C_WHOLE_W    = 64;

    typedef logic [C_CHAR_W-1:0]            t_char;
    typedef logic signed [C_VALUE_W-1:0]    t_value;
    typedef logic [C_STATUS_W-1:0]          t_status;
    typedef logic [C_CFG_IDX_W-1:0]         t_cfg_idx;
    typedef logic [C_CFG_DATA_W-1:0]        t_cfg_data;
    typedef logic [C_EXP_W-1:0]             t_exp;
    typedef logic [C_FCNT_W-1:0]            t_fcnt;
    typedef logic [C_MAG_W-1:0]             t_mag;
    typedef logic [C_WHOLE_W-1:0]           t_whole;

    localparam t_char C_CH_PLUS  = 8'h2B;
    localparam t_char C_CH_MINUS = 8'h2D;
    localparam t_char C_CH_DOT   = 8'h2E;
    localparam t_char C_CH_ZERO  = 8'h30;
    localparam t_char C_CH_NINE  = 8'h39;

    localparam t_cfg_idx C_CFG_FRAC_DIGITS  = 4'd0;
    localparam t_cfg_idx C_CFG_TOTAL_DIGITS = 4'd1;

    localparam t_cfg_data C_FRAC_DIGITS_RST  = 5'd2;
    localparam t_cfg_data C_TOTAL_DIGITS_RST = 5'd18;

    localparam t_status C_ST_OK    = 2'd0;
    localparam t_status C_ST_FRAC  = 2'd1;
    localparam t_status C_ST_RANGE = 2'd2;

    localparam t_exp C_EXP_MAX = C_EXP_W'(C_MAX_DIGITS);

    typedef struct packed {
        logic   negative;
        logic   overflowed;
        t_whole whole;
        t_mag   whole_scaled;
        t_mag   frac_scaled;
        logic   frac_nz;
        t_fcnt  frac_count;
    } t_finish;

    function automatic t_exp clamp_digits(input t_cfg_data v);
        clamp_digits = (v > C_EXP_MAX) ? C_EXP_MAX : v;
    endfunction

    function automatic t_whole pow10(input t_exp e);
        t_exp k;
        k = (e > C_EXP_MAX) ? C_EXP_MAX : e;
        case (k)
            5'd0:    pow10 = 64'd1;
            5'd1:    pow10 = 64'd10;
            5'd2:    pow10 = 64'd100;
            5'd3:    pow10 = 64'd1000;
            5'd4:    pow10 = 64'd10000;
            5'd5:    pow10 = 64'd100000;
            5'd6:    pow10 = 64'd1000000;
            5'd7:    pow10 = 64'd10000000;
            5'd8:    pow10 = 64'd100000000;
            5'd9:    pow10 = 64'd1000000000;
            5'd10:   pow10 = 64'd10000000000;
            5'd11:   pow10 = 64'd100000000000;
            5'd12:   pow10 = 64'd1000000000000;
            5'd13:   pow10 = 64'd10000000000000;
            5'd14:   pow10 = 64'd100000000000000;
            5'd15:   pow10 = 64'd1000000000000000;
            5'd16:   pow10 = 64'd10000000000000000;
            5'd17:   pow10 = 64'd100000000000000000;
            default: pow10 = 64'd1000000000000000000;
        endcase
    endfunction

endpackage

/* hw/rtl/dtsi_if.sv */
// ----------------------------------------------------------------------------
// dtsi interfaces
// Valid/ready channels for characters, results and register writes.
// ----------------------------------------------------------------------------
interface dtsi_char_if;
    logic             valid;
    logic             ready;
    dtsi_pkg::t_char  char_code;
    logic             last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface dtsi_result_if;
    logic              valid;
    logic              ready;
    dtsi_pkg::t_value  scaled_value;
    dtsi_pkg::t_status status;

    modport source (output valid, scaled_value, status, input ready);
    modport sink   (input valid, scaled_value, status, output ready);
endinterface

interface dtsi_cfg_if;
    logic                valid;
    logic                ready;
    dtsi_pkg::t_cfg_idx  index;
    dtsi_pkg::t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/decimal_text_to_scaled_integer_unit.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_integer_unit
// Parses a decimal literal, one character per word, into a signed integer
// scaled by ten to the configured number of fraction digits.
//
// Channels: i_char carries one character per word with last_char on the
// final one; o_result carries one word (scaled_value, status) per literal;
// i_cfg writes fraction_digits (index 0) and total_digits (index 1), always
// ready, to be used only while no literal is in flight.
// Throughput: one character per cycle, sustained across literals, unless a
// final character is held back by a stalled o_result. Path: the final
// character passes the input register, finish register and output register.
// A stalled o_result holds its word; characters that end no literal keep
// flowing, and a final character waits in the input register only while
// both the finish register and the output register are occupied.
// Reset clears the parse state and all valid flags and restores
// fraction_digits = 2, total_digits = 18.
// ----------------------------------------------------------------------------
`include "decimal_text_to_scaled_integer_unit_macros.svh"

module decimal_text_to_scaled_integer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dtsi_char_if.sink             i_char,
    dtsi_cfg_if.sink              i_cfg,
    dtsi_result_if.source         o_result
);

    localparam logic [1:0] PH_SIGN = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // configuration
    dtsi_pkg::t_cfg_data r_cfg_frac;
    dtsi_pkg::t_cfg_data r_cfg_total;
    dtsi_pkg::t_exp      fd;
    dtsi_pkg::t_exp      td;

    // handshake / stage control
    logic                r_s0_valid;
    dtsi_pkg::t_char     r_s0_char;
    logic                r_s0_last;
    logic                r_s1_valid;
    dtsi_pkg::t_finish   r_s1;
    logic                r_out_valid;
    dtsi_pkg::t_value    r_out_value;
    dtsi_pkg::t_status   r_out_status;
    logic                out_adv;
    logic                s1_adv;
    logic                s1_free;
    logic                s0_take;
    logic                in_ready;
    logic                in_acc;

    // parse state
    logic [1:0]          r_phase;
    logic                r_neg;
    dtsi_pkg::t_whole    r_whole;
    logic                r_ovf;
    dtsi_pkg::t_mag      r_ws;
    dtsi_pkg::t_mag      r_fs;
    logic                r_fnz;
    dtsi_pkg::t_fcnt     r_fcnt;

    logic [1:0]          n_phase;
    logic                n_neg;
    dtsi_pkg::t_whole    n_whole;
    logic                n_ovf;
    dtsi_pkg::t_mag      n_ws;
    dtsi_pkg::t_mag      n_fs;
    logic                n_fnz;
    dtsi_pkg::t_fcnt     n_fcnt;
    dtsi_pkg::t_finish   n_finish;

    logic                is_digit;
    logic [3:0]          digit;
    logic                take_whole;
    logic                take_frac;
    logic                whole_big;
    dtsi_pkg::t_mag      fd_scale;
    dtsi_pkg::t_exp      frac_exp;
    dtsi_pkg::t_mag      frac_scale;
    logic                frac_in_window;

    dtsi_pkg::t_value    fin_value;
    dtsi_pkg::t_status   fin_status;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frac  <= dtsi_pkg::C_FRAC_DIGITS_RST;
            r_cfg_total <= dtsi_pkg::C_TOTAL_DIGITS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dtsi_pkg::C_CFG_FRAC_DIGITS:  r_cfg_frac  <= i_cfg.data;
                dtsi_pkg::C_CFG_TOTAL_DIGITS: r_cfg_total <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign fd = dtsi_pkg::clamp_digits(r_cfg_frac);
    assign td = dtsi_pkg::clamp_digits(r_cfg_total);

    // ------------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------------
    assign out_adv  = !r_out_valid || o_result.ready;
    assign s1_adv   = r_s1_valid && out_adv;
    assign s1_free  = !r_s1_valid || out_adv;
    assign s0_take  = r_s0_valid && (!r_s0_last || s1_free);
    assign in_ready = !r_s0_valid || s0_take;
    assign in_acc   = i_char.valid && in_ready;

    assign i_char.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (in_acc) begin
            r_s0_valid <= 1'b1;
        end else if (s0_take) begin
            r_s0_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_char <= i_char.char_code;
            r_s0_last <= i_char.last_char;
        end
    end

    // ------------------------------------------------------------------------
    // Character decode and accumulator update
    // ------------------------------------------------------------------------
    assign is_digit  = (r_s0_char >= dtsi_pkg::C_CH_ZERO) && (r_s0_char <= dtsi_pkg::C_CH_NINE);
    assign digit     = 4'(r_s0_char - dtsi_pkg::C_CH_ZERO);
    assign whole_big = r_whole >= dtsi_pkg::pow10(dtsi_pkg::C_EXP_MAX);
    assign fd_scale  = dtsi_pkg::t_mag'(dtsi_pkg::pow10(fd));

    // fraction digit at position fcnt+1 weighs 10^(fd - fcnt - 1)
    assign frac_in_window = r_fcnt < dtsi_pkg::C_FCNT_W'(fd);
    assign frac_exp       = fd - r_fcnt[dtsi_pkg::C_EXP_W-1:0] - 5'd1;
    assign frac_scale     = dtsi_pkg::t_mag'(dtsi_pkg::pow10(frac_exp));

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_whole    = r_whole;
        n_ovf      = r_ovf;
        n_ws       = r_ws;
        n_fs       = r_fs;
        n_fnz      = r_fnz;
        n_fcnt     = r_fcnt;
        take_whole = 1'b0;
        take_frac  = 1'b0;

        case (r_phase)
            PH_SIGN: begin
                if (r_s0_char == dtsi_pkg::C_CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_INT;
                end else if (r_s0_char == dtsi_pkg::C_CH_PLUS) begin
                    n_phase = PH_INT;
                end else if (is_digit) begin
                    take_whole = 1'b1;
                    n_phase    = PH_INT;
                end else if (r_s0_char == dtsi_pkg::C_CH_DOT) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    take_whole = 1'b1;
                end else if (r_s0_char == dtsi_pkg::C_CH_DOT) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    take_frac = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase

        if (take_whole) begin
            if (whole_big) begin
                n_ovf = 1'b1;
            end else begin
                n_whole = (r_whole << 3) + (r_whole << 1) + dtsi_pkg::t_whole'(digit);
                // wraps only when the whole part is out of range anyway
                n_ws    = (r_ws << 3) + (r_ws << 1)
                        + dtsi_pkg::t_mag'(fd_scale * dtsi_pkg::t_mag'(digit));
            end
        end

        if (take_frac) begin
            if (frac_in_window) begin
                n_fs = r_fs + dtsi_pkg::t_mag'(frac_scale * dtsi_pkg::t_mag'(digit));
            end
            if (digit != 4'd0) begin
                n_fnz = 1'b1;
            end
            if (!(&r_fcnt)) begin
                n_fcnt = r_fcnt + dtsi_pkg::t_fcnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s0_take && r_s0_last)) begin
            r_phase <= PH_SIGN;
            r_neg   <= 1'b0;
            r_whole <= '0;
            r_ovf   <= 1'b0;
            r_ws    <= '0;
            r_fs    <= '0;
            r_fnz   <= 1'b0;
            r_fcnt  <= '0;
        end else if (s0_take) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_whole <= n_whole;
            r_ovf   <= n_ovf;
            r_ws    <= n_ws;
            r_fs    <= n_fs;
            r_fnz   <= n_fnz;
            r_fcnt  <= n_fcnt;
        end
    end

    // ------------------------------------------------------------------------
    // Finish register
    // ------------------------------------------------------------------------
    always_comb begin
        n_finish.negative     = n_neg;
        n_finish.overflowed   = n_ovf;
        n_finish.whole        = n_whole;
        n_finish.whole_scaled = n_ws;
        n_finish.frac_scaled  = n_fs;
        n_finish.frac_nz      = n_fnz;
        n_finish.frac_count   = n_fcnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_take && r_s0_last) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_take && r_s0_last) begin
            r_s1 <= n_finish;
        end
    end

    dtsi_finish u_finish (
        .i_fin          (r_s1),
        .i_frac_digits  (fd),
        .i_total_digits (td),
        .o_value        (fin_value),
        .o_status       (fin_status)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value  <= fin_value;
            r_out_status <= fin_status;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.scaled_value = r_out_value;
    assign o_result.status       = r_out_status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DTSI_ASSERT_NEXT(a_last_loads_finish, i_clk, i_rst_n,
        s0_take && r_s0_last, r_s1_valid, "final character did not reach finish register")

    `DTSI_ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n,
        s0_take && r_s0_last,
        (r_phase == PH_SIGN) && !r_neg && !r_ovf && (r_whole == '0) && (r_fcnt == '0),
        "parse state not cleared after final character")

    `DTSI_ASSERT_SAME(a_last_blocks_input, i_clk, i_rst_n,
        r_s0_valid && r_s0_last && !s1_free, !i_char.ready,
        "input accepted while final character is blocked")

    `DTSI_ASSERT_SAME(a_frac_status_zero, i_clk, i_rst_n,
        o_result.valid && (o_result.status == dtsi_pkg::C_ST_FRAC),
        o_result.scaled_value == '0,
        "fraction status with nonzero value")

endmodule

/* hw/rtl/dtsi_finish.sv */
// ----------------------------------------------------------------------------
// dtsi_finish
// Turns the captured accumulators of one literal into the signed scaled
// value and status: fraction-digit check, range checks, saturation and sign.
// ----------------------------------------------------------------------------
module dtsi_finish (
    input  dtsi_pkg::t_finish i_fin,
    input  dtsi_pkg::t_exp    i_frac_digits,
    input  dtsi_pkg::t_exp    i_total_digits,
    output dtsi_pkg::t_value  o_value,
    output dtsi_pkg::t_status o_status
);

    logic                            td_ge_fd;
    dtsi_pkg::t_exp                  whole_exp;
    dtsi_pkg::t_whole                whole_limit;
    dtsi_pkg::t_mag                  total_limit;
    dtsi_pkg::t_mag                  sat_mag;
    logic                            st_frac;
    logic                            st_range;
    logic [dtsi_pkg::C_VALUE_W-1:0]  inv;
    logic [dtsi_pkg::C_VALUE_W-1:0]  sum;
    logic [dtsi_pkg::C_VALUE_W-1:0]  sat_val;

    // Whole part must stay below 10^(total - frac); below 1 when total < frac.
    assign td_ge_fd    = i_total_digits >= i_frac_digits;
    assign whole_exp   = td_ge_fd ? (i_total_digits - i_frac_digits) : '0;
    assign whole_limit = dtsi_pkg::pow10(whole_exp);
    assign total_limit = dtsi_pkg::t_mag'(dtsi_pkg::pow10(i_total_digits));
    assign sat_mag     = total_limit - dtsi_pkg::t_mag'(1);

    assign st_frac  = i_fin.frac_nz
                      && (i_fin.frac_count > dtsi_pkg::C_FCNT_W'(i_frac_digits));
    // Fraction alone can exceed the limit only when total < frac (whole is 0 then).
    assign st_range = i_fin.overflowed
                      || (i_fin.whole >= whole_limit)
                      || (i_fin.frac_scaled >= total_limit);

    // -(a + b) = ~a + ~b + 2
    assign inv = {dtsi_pkg::C_VALUE_W{i_fin.negative}};
    assign sum = ({1'b0, i_fin.whole_scaled} ^ inv)
               + ({1'b0, i_fin.frac_scaled} ^ inv)
               + {{(dtsi_pkg::C_VALUE_W-2){1'b0}}, i_fin.negative, 1'b0};

    assign sat_val = i_fin.negative ? (dtsi_pkg::C_VALUE_W'(0) - {1'b0, sat_mag})
                                    : {1'b0, sat_mag};

    always_comb begin
        if (st_frac) begin
            o_value  = '0;
            o_status = dtsi_pkg::C_ST_FRAC;
        end else if (st_range) begin
            o_value  = dtsi_pkg::t_value'(sat_val);
            o_status = dtsi_pkg::C_ST_RANGE;
        end else begin
            o_value  = dtsi_pkg::t_value'(sum);
            o_status = dtsi_pkg::C_ST_OK;
        end
    end

endmodule
